/* sv/ctm_pkg.sv */
package ctm_pkg;

  localparam int DIG_BITS = 36;
  localparam int CNT_BITS = 4;
  localparam int KEY_BITS = 4;
  localparam int IDX_BITS = 5;
  localparam int STS_BITS = 3;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_FIND_NUM = 2'd1;
  localparam logic [1:0] CMD_FIND_KEY = 2'd2;

  localparam logic [STS_BITS-1:0] STS_OK        = 3'd0;
  localparam logic [STS_BITS-1:0] STS_NOT_FOUND = 3'd1;
  localparam logic [STS_BITS-1:0] STS_FULL      = 3'd2;
  localparam logic [STS_BITS-1:0] STS_DUP       = 3'd3;
  localparam logic [STS_BITS-1:0] STS_KEY       = 3'd4;

  localparam logic [KEY_BITS-1:0] NO_KEY  = 4'hF;
  localparam logic [KEY_BITS-1:0] MAX_KEY = 4'd9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctm_state_t;

  typedef struct packed {
    logic [DIG_BITS-1:0] digits;
    logic [CNT_BITS-1:0] count;
    logic [KEY_BITS-1:0] key;
  } ctm_entry_t;

  typedef struct packed {
    logic [1:0] cmd;
    ctm_entry_t ent;
    logic       key_bad;
  } ctm_query_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ctm_mem_req_t;

  typedef struct packed {
    logic num_hit;
    logic key_hit;
  } ctm_hit_t;

  // Keep the low n nibbles, clear the rest.
  function automatic logic [DIG_BITS-1:0] keep_digits(input logic [DIG_BITS-1:0] d,
                                                      input logic [CNT_BITS-1:0] n);
    logic [DIG_BITS-1:0] m;
    m = '0;
    for (int j = 0; j < DIG_BITS / 4; j++) begin
      if (CNT_BITS'(j) < n) begin
        m[j*4 +: 4] = 4'hF;
      end
    end
    return d & m;
  endfunction

endpackage

/* sv/ctm_entry_mem.sv */
module ctm_entry_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  ctm_pkg::ctm_mem_req_t req,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  ctm_pkg::ctm_entry_t   wr_data,
  output ctm_pkg::ctm_entry_t   rd_data
);
  import ctm_pkg::*;

  ctm_entry_t mem [DEPTH];
  ctm_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/ctm_match.sv */
module ctm_match (
  input  ctm_pkg::ctm_entry_t entry,
  input  ctm_pkg::ctm_entry_t query,
  output ctm_pkg::ctm_hit_t   hit
);
  import ctm_pkg::*;

  // Anonymous numbers (count zero) never match.
  assign hit.num_hit = (query.count != '0) && (entry.count != '0) &&
                       (entry.count == query.count) && (entry.digits == query.digits);
  assign hit.key_hit = (entry.key == query.key);

endmodule

/* sv/contact_table_match_unit.sv */
// Contact table match unit: append-only table of phone numbers and quick-dial keys.
//
// Input channel (in_valid / in_stall): one beat carries a command, the packed BCD
// number, its digit count and a signed quick-dial key. Add appends an entry unless
// the table is full, the number is already stored or the key is taken; the two find
// commands return the lowest matching entry index.
// Output channel (out_valid / out_stall): one beat per input beat, carrying status
// and entry index, in order.
//
// One input beat at a time. The accept edge latches the
// beat; the scan then reads one entry per cycle through the single read port,
// compares it the cycle after, and ends once no read is pending or left to issue.
// A hit ends the scan early, and a beat that needs no scan skips it; the next
// beat is taken in the cycle after the post. in_stall is high from accept
// until the post.
// Reset clears the entry count and all control; the entry memory is left as is,
// since only entries below the count are ever read. No clearing pass is run.
// While the receiver stalls, the output register holds its beat; the next beat
// may be accepted and scanned, and waits at the end of its scan until the
// output register frees up.
module contact_table_match_unit #(
  parameter int MAX_ENTRIES  = 32,
  parameter int MATCH_DIGITS = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [ctm_pkg::DIG_BITS-1:0]    in_number_digits,
  input  logic [ctm_pkg::CNT_BITS-1:0]    in_digit_count,
  input  logic signed [4:0]               in_quick_dial,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ctm_pkg::STS_BITS-1:0]    out_status,
  output logic [ctm_pkg::IDX_BITS-1:0]    out_entry_index
);
  import ctm_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  ctm_state_t state_r, state_nxt;
  ctm_query_t q_r, q_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic [STS_BITS-1:0] res_status_r, res_status_nxt;
  logic [AW-1:0] res_idx_r, res_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [STS_BITS-1:0] out_status_r, out_status_nxt;
  logic [IDX_BITS-1:0] out_index_r, out_index_nxt;

  ctm_mem_req_t mem_req;
  ctm_entry_t   rd_data;
  ctm_hit_t     hit;
  ctm_query_t   in_q;
  logic [CNT_BITS-1:0] in_n;
  logic [4:0]   key_raw;
  logic [KEY_BITS-1:0] find_key;
  logic         deliver;
  logic [AW+IDX_BITS-1:0] idx_ext;

  // Saturate the digit count and mask off nibbles above it.
  always_comb begin
    if ({1'b0, in_digit_count} > 5'(MATCH_DIGITS)) begin
      in_n = CNT_BITS'(MATCH_DIGITS);
    end else begin
      in_n = in_digit_count;
    end
  end

  // Key decode: 0..9 stand as is, -1 is "no key", anything else is bad.
  assign key_raw = in_quick_dial;
  always_comb begin
    find_key = NO_KEY;
    in_q.key_bad = 1'b0;
    if (key_raw <= {1'b0, MAX_KEY}) begin
      find_key = key_raw[KEY_BITS-1:0];
    end else if (key_raw != 5'h1F) begin
      in_q.key_bad = 1'b1;
    end
    in_q.cmd = in_cmd;
    in_q.ent.digits = keep_digits(in_number_digits, in_n);
    in_q.ent.count = in_n;
    // An add with any key outside 0..9 stores no key.
    if (in_cmd == CMD_ADD && in_q.key_bad) begin
      in_q.ent.key = NO_KEY;
    end else begin
      in_q.ent.key = find_key;
    end
  end

  ctm_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_addr (issue_r[AW-1:0]),
    .wr_addr (used_r[AW-1:0]),
    .wr_data (q_r.ent),
    .rd_data (rd_data)
  );

  ctm_match u_match (
    .entry (rd_data),
    .query (q_r.ent),
    .hit   (hit)
  );

  assign in_stall = (state_r != S_IDLE);
  assign deliver  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    used_nxt       = used_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    mem_req        = '0;
    idx_ext        = {{IDX_BITS{1'b0}}, res_idx_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_nxt          = in_q;
          issue_nxt      = '0;
          res_idx_nxt    = '0;
          res_status_nxt = STS_NOT_FOUND;
          state_nxt      = S_SCAN;
          case (in_cmd)
            CMD_ADD: begin
              if (used_r >= CW'(MAX_ENTRIES)) begin
                res_status_nxt = STS_FULL;
                state_nxt      = S_DONE;
              end else begin
                res_status_nxt = STS_OK;
              end
            end
            CMD_FIND_NUM: begin
              state_nxt = S_SCAN;
            end
            CMD_FIND_KEY: begin
              if (in_q.key_bad) begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, compare the entry read the cycle before.
        mem_req.rd_en = (issue_r < used_r);
        if (mem_req.rd_en) begin
          issue_nxt    = issue_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[AW-1:0];
        end
        if (pend_r) begin
          case (q_r.cmd)
            CMD_ADD: begin
              if (hit.num_hit) begin
                res_status_nxt = STS_DUP;
                state_nxt      = S_DONE;
              end else if (hit.key_hit && q_r.ent.key != NO_KEY) begin
                res_status_nxt = STS_KEY;
                state_nxt      = S_DONE;
              end
            end
            CMD_FIND_NUM: begin
              if (hit.num_hit) begin
                res_status_nxt = STS_OK;
                res_idx_nxt    = pend_idx_r;
                state_nxt      = S_DONE;
              end
            end
            CMD_FIND_KEY: begin
              if (hit.key_hit) begin
                res_status_nxt = STS_OK;
                res_idx_nxt    = pend_idx_r;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (!mem_req.rd_en) begin
          state_nxt = S_DONE;
        end
        // Drop any read still in flight once the scan ends.
        if (state_nxt != S_SCAN) begin
          pend_nxt = 1'b0;
        end
      end

      S_DONE: begin
        // Hold until the output register is free, then post and commit a successful add.
        if (deliver) begin
          if (q_r.cmd == CMD_ADD && res_status_r == STS_OK) begin
            mem_req.wr_en = 1'b1;
            used_nxt      = used_r + 1'b1;
            idx_ext       = {{IDX_BITS{1'b0}}, used_r[AW-1:0]};
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = idx_ext[IDX_BITS-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_add_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && deliver && q_r.cmd == CMD_ADD && res_status_r == STS_OK)
    |=> (used_r == $past(used_r) + 1'b1))
    else $error("successful add did not advance the entry count");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("compare pending outside scan");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STS_FULL) |-> (used_r == CW'(MAX_ENTRIES)))
    else $error("table full reported while entries remain");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == S_DONE && !mem_req.rd_en))
    else $error("entry write outside result post");

endmodule
